/* src/nrpl_pkg.sv */
package nrpl_pkg;

    localparam int CHAN_W   = 8;
    localparam int COUNT_W  = 12;
    localparam int DIST_W   = 18;
    localparam int WIDTH_W  = 13;

    localparam logic [CHAN_W-1:0]  FULL_RED    = 8'd255;
    localparam logic [WIDTH_W-1:0] WIDTH_RESET = 13'd640;
    localparam logic [DIST_W-1:0]  DIST_INIT   = '1;

    localparam int DEFAULT_MAX_WIDTH  = 4096;
    localparam int DEFAULT_MAX_HEIGHT = 4096;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic              frame_end;
    } pixel_t;

    typedef struct packed {
        logic [DIST_W-1:0] distance;
        logic              frame_end;
    } item_t;

endpackage

/* src/nrpl_if.sv */
interface nrpl_pixel_if
    import nrpl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] red;
    logic              frame_end;

    modport source (output valid, output blue, output green, output red,
                    output frame_end, input ready);
    modport sink   (input valid, input blue, input green, input red,
                    input frame_end, output ready);
endinterface

interface nrpl_result_if
    import nrpl_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] best_row;
    logic [COUNT_W-1:0] best_column;
    logic [DIST_W-1:0]  best_distance;

    modport source (output valid, output best_row, output best_column,
                    output best_distance, input ready);
    modport sink   (input valid, input best_row, input best_column,
                    input best_distance, output ready);
endinterface

/* src/nearest_red_pixel_locator.sv */
// Finds, per frame, the pixel whose colour lies nearest to pure red, using the squared
// distance (red-255)^2 + green^2 + blue^2, the first pixel in raster order winning ties.
// Pixels stream in raster order; column and row follow frame_width (0 acts as 1, values
// above MAX_WIDTH act as MAX_WIDTH) and rows wrap after MAX_HEIGHT. One pixel is taken
// every clock. A pixel goes through the input register and then the running-minimum
// update, and the result for a frame is registered there once its frame_end pixel has
// passed both; the only stall is a frame_end pixel meeting a result that has not yet
// been taken. frame_width should be written only while no pixels are in flight.
module nearest_red_pixel_locator
    import nrpl_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [WIDTH_W-1:0] cfg_wdata,
    nrpl_pixel_if.sink         pixel,
    nrpl_result_if.source      result
);

    logic [WIDTH_W-1:0] frame_width_reg;
    logic               in_valid_reg, in_valid_next;
    pixel_t             in_pixel_reg, in_pixel_next;

    logic              in_fire;
    logic              item_ready;
    logic [DIST_W-1:0] distance;
    item_t             item;

    assign pixel.ready = !in_valid_reg || item_ready;
    assign in_fire     = pixel.valid && pixel.ready;

    always_comb
    begin
        in_valid_next = in_valid_reg && !item_ready;
        in_pixel_next = in_pixel_reg;
        if (in_fire)
        begin
            in_valid_next = 1'b1;
            in_pixel_next = '{blue: pixel.blue, green: pixel.green, red: pixel.red,
                              frame_end: pixel.frame_end};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg <= WIDTH_RESET;
            in_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                frame_width_reg <= cfg_wdata;
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_pixel_reg <= in_pixel_next;
    end

    nrpl_dist u_dist
    (
        .pixel    (in_pixel_reg),
        .distance (distance)
    );

    assign item = '{distance: distance, frame_end: in_pixel_reg.frame_end};

    nrpl_track #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_track
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_width (frame_width_reg),
        .item_valid  (in_valid_reg),
        .item        (item),
        .item_ready  (item_ready),
        .result      (result)
    );

endmodule

/* src/nrpl_dist.sv */
module nrpl_dist
    import nrpl_pkg::*;
(
    input  pixel_t            pixel,
    output logic [DIST_W-1:0] distance
);

    logic [CHAN_W-1:0]   red_gap;
    logic [2*CHAN_W-1:0] red_sq;
    logic [2*CHAN_W-1:0] green_sq;
    logic [2*CHAN_W-1:0] blue_sq;

    always_comb
    begin
        red_gap  = FULL_RED - pixel.red;
        red_sq   = red_gap * red_gap;
        green_sq = pixel.green * pixel.green;
        blue_sq  = pixel.blue * pixel.blue;
        distance = DIST_W'(red_sq) + DIST_W'(green_sq) + DIST_W'(blue_sq);
    end

endmodule

/* src/nrpl_track.sv */
module nrpl_track
    import nrpl_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [WIDTH_W-1:0] frame_width,
    input  logic               item_valid,
    input  item_t              item,
    output logic               item_ready,
    nrpl_result_if.source      result
);

    localparam int MW_W  = $clog2(MAX_WIDTH + 1);
    localparam int CMP_W = (MW_W > WIDTH_W + 1) ? MW_W : WIDTH_W + 1;
    localparam int MH_W  = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W = (MH_W > COUNT_W + 1) ? MH_W : COUNT_W + 1;

    logic [COUNT_W-1:0] column_count_reg, column_count_next;
    logic [COUNT_W-1:0] row_count_reg,    row_count_next;
    logic [DIST_W-1:0]  least_distance_reg, least_distance_next;
    logic [COUNT_W-1:0] least_row_reg,    least_row_next;
    logic [COUNT_W-1:0] least_column_reg, least_column_next;

    logic               out_valid_reg, out_valid_next;
    logic [COUNT_W-1:0] out_row_reg,    out_row_next;
    logic [COUNT_W-1:0] out_column_reg, out_column_next;
    logic [DIST_W-1:0]  out_distance_reg, out_distance_next;

    logic               fire;
    logic               better;
    logic [DIST_W-1:0]  best_d;
    logic [COUNT_W-1:0] best_r;
    logic [COUNT_W-1:0] best_c;
    logic [CMP_W-1:0]   width_ext;
    logic [CMP_W-1:0]   eff_width;
    logic [CMP_W-1:0]   column_inc;
    logic [ROW_W-1:0]   row_inc;

    assign item_ready = !item.frame_end || !out_valid_reg || result.ready;
    assign fire       = item_valid && item_ready;

    assign result.valid         = out_valid_reg;
    assign result.best_row      = out_row_reg;
    assign result.best_column   = out_column_reg;
    assign result.best_distance = out_distance_reg;

    always_comb
    begin
        better = item.distance < least_distance_reg;
        best_d = better ? item.distance : least_distance_reg;
        best_r = better ? row_count_reg : least_row_reg;
        best_c = better ? column_count_reg : least_column_reg;

        width_ext = CMP_W'(frame_width);
        if (width_ext == '0)
            eff_width = CMP_W'(1);
        else if (width_ext > CMP_W'(MAX_WIDTH))
            eff_width = CMP_W'(MAX_WIDTH);
        else
            eff_width = width_ext;

        column_inc = CMP_W'(column_count_reg) + CMP_W'(1);
        row_inc    = ROW_W'(row_count_reg) + ROW_W'(1);

        column_count_next   = column_count_reg;
        row_count_next      = row_count_reg;
        least_distance_next = least_distance_reg;
        least_row_next      = least_row_reg;
        least_column_next   = least_column_reg;

        out_valid_next    = out_valid_reg && !result.ready;
        out_row_next      = out_row_reg;
        out_column_next   = out_column_reg;
        out_distance_next = out_distance_reg;

        if (fire)
        begin
            if (item.frame_end)
            begin
                out_valid_next      = 1'b1;
                out_row_next        = best_r;
                out_column_next     = best_c;
                out_distance_next   = best_d;
                column_count_next   = '0;
                row_count_next      = '0;
                least_distance_next = DIST_INIT;
                least_row_next      = '0;
                least_column_next   = '0;
            end
            else
            begin
                least_distance_next = best_d;
                least_row_next      = best_r;
                least_column_next   = best_c;
                if (column_inc >= eff_width)
                begin
                    column_count_next = '0;
                    if (row_inc >= ROW_W'(MAX_HEIGHT))
                        row_count_next = '0;
                    else
                        row_count_next = row_inc[COUNT_W-1:0];
                end
                else
                begin
                    column_count_next = column_inc[COUNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg   <= '0;
            row_count_reg      <= '0;
            least_distance_reg <= DIST_INIT;
            least_row_reg      <= '0;
            least_column_reg   <= '0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            column_count_reg   <= column_count_next;
            row_count_reg      <= row_count_next;
            least_distance_reg <= least_distance_next;
            least_row_reg      <= least_row_next;
            least_column_reg   <= least_column_next;
            out_valid_reg      <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_row_reg      <= out_row_next;
        out_column_reg   <= out_column_next;
        out_distance_reg <= out_distance_next;
    end

endmodule

/* tb/sv/nrpl_checker.sv */
module nrpl_checker
    import nrpl_pkg::*;
#(
    parameter int MAX_WIDTH  = DEFAULT_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEFAULT_MAX_HEIGHT
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [WIDTH_W-1:0] cfg_wdata,
    nrpl_pixel_if              pixel,
    nrpl_result_if             result,
    output int                 mismatches,
    output int                 outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [COUNT_W-1:0] row;
        logic [COUNT_W-1:0] column;
        logic [DIST_W-1:0]  distance;
    } red_hit_t;

    red_hit_t           hits_due[$];
    red_hit_t           due;
    logic [WIDTH_W-1:0] frame_width;
    logic [COUNT_W-1:0] column_now;
    logic [COUNT_W-1:0] row_now;
    logic [COUNT_W-1:0] nearest_row;
    logic [COUNT_W-1:0] nearest_column;
    logic [DIST_W-1:0]  nearest_gap;
    logic [DIST_W-1:0]  gap;
    int                 row_len;

    function automatic logic [DIST_W-1:0] red_gap(input logic [CHAN_W-1:0] b,
                                                  input logic [CHAN_W-1:0] g,
                                                  input logic [CHAN_W-1:0] r);
        int dr;
        dr = int'(FULL_RED) - int'(r);
        return DIST_W'(dr * dr + int'(g) * int'(g) + int'(b) * int'(b));
    endfunction

    function automatic void clear_frame();
        column_now     = '0;
        row_now        = '0;
        nearest_gap    = DIST_INIT;
        nearest_row    = '0;
        nearest_column = '0;
    endfunction

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width = WIDTH_RESET;
            clear_frame();
            hits_due.delete();
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                if (hits_due.size() == 0)
                begin
                    $error("unexpected result transaction: row %0d column %0d distance %0d",
                           result.best_row, result.best_column, result.best_distance);
                    mismatches++;
                end
                else
                begin
                    due = hits_due.pop_front();
                    if (result.best_row !== due.row)
                    begin
                        $error("best_row expected %0d actual %0d", due.row, result.best_row);
                        mismatches++;
                    end
                    if (result.best_column !== due.column)
                    begin
                        $error("best_column expected %0d actual %0d",
                               due.column, result.best_column);
                        mismatches++;
                    end
                    if (result.best_distance !== due.distance)
                    begin
                        $error("best_distance expected %0d actual %0d",
                               due.distance, result.best_distance);
                        mismatches++;
                    end
                end
            end

            if (pixel.valid && pixel.ready)
            begin
                gap = red_gap(pixel.blue, pixel.green, pixel.red);
                // strict compare, so the earliest pixel keeps a tie
                if (gap < nearest_gap)
                begin
                    nearest_gap    = gap;
                    nearest_row    = row_now;
                    nearest_column = column_now;
                end
                if (pixel.frame_end)
                begin
                    hits_due.push_back('{nearest_row, nearest_column, nearest_gap});
                    clear_frame();
                end
                else
                begin
                    if (frame_width == 0)
                        row_len = 1;
                    else if (int'(frame_width) > MAX_WIDTH)
                        row_len = MAX_WIDTH;
                    else
                        row_len = int'(frame_width);
                    if (int'(column_now) + 1 >= row_len)
                    begin
                        column_now = '0;
                        if (int'(row_now) + 1 >= MAX_HEIGHT)
                            row_now = '0;
                        else
                            row_now = row_now + 1'b1;
                    end
                    else
                        column_now = column_now + 1'b1;
                end
            end

            if (cfg_we)
                frame_width = cfg_wdata;
        end
        outstanding = hits_due.size();
    end

endmodule

/* tb/sv/tb_nearest_red_pixel_locator.sv */
module tb_nearest_red_pixel_locator;
    timeunit 1ns;
    timeprecision 1ps;

    import nrpl_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 33;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 1500;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [WIDTH_W-1:0] cfg_wdata;
    int                 mismatches;
    int                 outstanding;
    int                 cycles;
    bit                 steady;
    bit                 hold_go;

    nrpl_pixel_if  pixel_ch ();
    nrpl_result_if result_ch ();

    nearest_red_pixel_locator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pixel     (pixel_ch),
        .result    (result_ch)
    );

    nrpl_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .pixel       (pixel_ch),
        .result      (result_ch),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        int held;
        result_ch.ready <= 1'b0;
        forever
        begin
            if (hold_go)
            begin
                hold_go = 1'b0;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    result_ch.ready <= 1'b0;
                    @(posedge clk);
                    held++;
                end
            end
            result_ch.ready <= rst_n && (steady || $urandom_range(99) >= IDLE_PCT);
            @(posedge clk);
        end
    end

    task automatic send_pixel(input logic [CHAN_W-1:0] b, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] r, input logic last);
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            pixel_ch.valid     <= 1'b0;
            pixel_ch.blue      <= CHAN_W'($urandom);
            pixel_ch.green     <= CHAN_W'($urandom);
            pixel_ch.red       <= CHAN_W'($urandom);
            pixel_ch.frame_end <= 1'($urandom);
            @(posedge clk);
        end
        pixel_ch.valid     <= 1'b1;
        pixel_ch.blue      <= b;
        pixel_ch.green     <= g;
        pixel_ch.red       <= r;
        pixel_ch.frame_end <= last;
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
    endtask

    function automatic pixel_t random_pixel();
        pixel_t px;
        px = pixel_t'($urandom);
        px.frame_end = 1'b0;
        case ($urandom_range(9))
            4, 5:
            begin
                px.red   = FULL_RED - CHAN_W'($urandom_range(15));
                px.green = CHAN_W'($urandom_range(15));
                px.blue  = CHAN_W'($urandom_range(15));
            end
            6:
            begin
                px.red   = FULL_RED;
                px.green = '0;
                px.blue  = '0;
            end
            // small palette so that equal distances turn up often
            7:
            begin
                case ($urandom_range(3))
                    0: {px.blue, px.green, px.red} = {8'd0, 8'd0, 8'd254};
                    1: {px.blue, px.green, px.red} = {8'd1, 8'd0, 8'd255};
                    2: {px.blue, px.green, px.red} = {8'd0, 8'd1, 8'd255};
                    default: {px.blue, px.green, px.red} = {8'd3, 8'd4, 8'd255};
                endcase
            end
            8:
            begin
                px.blue  = {CHAN_W{px.blue[0]}};
                px.green = {CHAN_W{px.blue[0]}};
                px.red   = {CHAN_W{px.blue[0]}};
            end
            9:
            begin
                px.red   = '0;
                px.green = '1;
                px.blue  = '1;
            end
            default: ;
        endcase
        return px;
    endfunction

    task automatic settle();
        pixel_ch.valid <= 1'b0;
        repeat (3) @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_width(input logic [WIDTH_W-1:0] w);
        cfg_we    <= 1'b1;
        cfg_wdata <= w;
        @(posedge clk);
        cfg_we    <= 1'b0;
        cfg_wdata <= WIDTH_W'($urandom);
        @(posedge clk);
    endtask

    task automatic random_run(input int count, input int longest, inout int frame_left);
        pixel_t px;
        repeat (count)
        begin
            px = random_pixel();
            frame_left--;
            send_pixel(px.blue, px.green, px.red, frame_left == 0);
            if (frame_left == 0)
                frame_left = $urandom_range(longest, 1);
        end
    endtask

    initial
    begin
        int sent;
        int run_len;
        int longest;
        int frame_left;
        bit held_once;
        logic [WIDTH_W-1:0] w;

        rst_n              <= 1'b0;
        cfg_we             <= 1'b0;
        cfg_wdata          <= '0;
        pixel_ch.valid     <= 1'b0;
        pixel_ch.blue      <= '0;
        pixel_ch.green     <= '0;
        pixel_ch.red       <= '0;
        pixel_ch.frame_end <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // farthest colour as a one-pixel frame
        send_pixel(8'd255, 8'd255, 8'd0, 1'b1);
        // black, white, near red twice, pure red, ends on black
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd255, 8'd255, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd254, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd254, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        // all equal, first one wins
        repeat (3) send_pixel(8'd10, 8'd20, 8'd200, 1'b0);
        send_pixel(8'd10, 8'd20, 8'd200, 1'b1);
        // best pixel is the last of the frame
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd1, 8'd0, 8'd255, 1'b1);
        // narrow the row mid-frame with the column already past it
        repeat (5) send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        settle();
        write_width(13'd2);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);
        // zero width behaves as one pixel per row
        settle();
        write_width(13'd0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd255, 1'b0);
        send_pixel(8'd0, 8'd0, 8'd0, 1'b1);

        sent = 0;
        held_once = 1'b0;
        frame_left = $urandom_range(40, 1);
        while (sent < RANDOM_ITEMS)
        begin
            settle();
            case ($urandom_range(7))
                0: w = 13'd1;
                1: w = 13'd0;
                2: w = 13'd4096;
                3: w = WIDTH_W'($urandom_range(8191, 4097));
                4: w = 13'd8191;
                5: w = 13'd640;
                default: w = WIDTH_W'($urandom_range(48, 2));
            endcase
            write_width(w);
            steady = ($urandom_range(4) == 0);
            run_len = $urandom_range(150, 20);
            longest = ($urandom_range(3) == 0) ? 3 : 40;
            if (!held_once && sent > RANDOM_ITEMS / 3)
            begin
                held_once = 1'b1;
                hold_go = 1'b1;
                longest = 2;
            end
            random_run(run_len, longest, frame_left);
            sent += run_len;
        end

        // close any open frame
        send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 1'b1);
        settle();

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

/* nearest_red_pixel_locator.f */
src/nrpl_pkg.sv
src/nrpl_if.sv
src/nrpl_dist.sv
src/nrpl_track.sv
src/nearest_red_pixel_locator.sv
tb/sv/nrpl_checker.sv
tb/sv/tb_nearest_red_pixel_locator.sv
